[sv/fgs_pkg.sv]
// Shared types, constants and lookup tables of the fuzzy gain scheduler.
`timescale 1ns / 1ps

package fgs_pkg;

  localparam int unsigned Rank       = 7;
  localparam int unsigned CentreW    = 9;
  localparam int unsigned CfgW       = Rank * CentreW;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned RecipShift = 20;

  localparam logic [2:0] LastIdx = 3'(Rank - 1);

  // Register indexes of the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    CfgPGain = 2'd0,
    CfgDGain = 2'd1,
    CfgSpeed = 2'd2
  } cfg_idx_e;

  localparam logic [CfgW-1:0] PGainReset = 63'd3321135574393637023;
  localparam logic [CfgW-1:0] DGainReset = 63'd2887379123326472288;
  localparam logic [CfgW-1:0] SpeedReset = 63'd6425534729258182464;

  typedef struct packed {
    logic signed [15:0] track_offset;
    logic signed [15:0] offset_change;
  } in_word_t;

  typedef struct packed {
    logic [CentreW-1:0] p_gain;
    logic [CentreW-1:0] d_gain;
    logic [CentreW-1:0] speed_level;
  } out_word_t;

  // Classified word: cell indexes and membership weights of both inputs
  typedef struct packed {
    logic [2:0] pe;
    logic [2:0] pe1;
    logic [2:0] pc;
    logic [2:0] pc1;
    logic [5:0] ea0;
    logic [5:0] ea1;
    logic [4:0] ca0;
    logic [4:0] ca1;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [2:0] pc;
    logic [4:0] ca0;
    logic [4:0] ca1;
  } chg_t;

  // Error breakpoints
  localparam logic [7:0] EBp [Rank] = '{8'd0, 8'd23, 8'd49, 8'd80, 8'd111, 8'd148, 8'd195};

  // Rule tables, indexed [change cell][error cell]
  localparam logic [2:0] KpRules [Rank][Rank] = '{
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
    '{3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
    '{3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2},
    '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3}
  };

  localparam logic [2:0] KdRules [Rank][Rank] = '{
    '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6},
    '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5},
    '{3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5},
    '{3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
    '{3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3},
    '{3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2}
  };

  localparam logic [2:0] SpeedRow [Rank] = '{3'd3, 3'd4, 3'd5, 3'd5, 3'd2, 3'd1, 3'd1};

  // floor(2^RecipShift / (2 * den)), indexed [error cell][change class]
  // change class: cells 0-1 span 9, cells 2-5 span 18, last cell spans 1
  localparam logic [RecipShift-1:0] RecipTab [Rank][3] = '{
    '{20'd2532,  20'd1266,  20'd22795},
    '{20'd2240,  20'd1120,  20'd20164},
    '{20'd1879,  20'd939,   20'd16912},
    '{20'd1879,  20'd939,   20'd16912},
    '{20'd1574,  20'd787,   20'd14169},
    '{20'd1239,  20'd619,   20'd11155},
    '{20'd58254, 20'd29127, 20'd524288}
  };

  // Change magnitude (clamped to 9) placed on breakpoints 0,0.9,...,9
  // in tenths: cell and the two weights.
  function automatic chg_t chg_locate(logic [3:0] m);
    chg_t r;
    unique case (m)
      4'd0:    r = '{pc: 3'd0, ca0: 5'd9,  ca1: 5'd0};
      4'd1:    r = '{pc: 3'd1, ca0: 5'd8,  ca1: 5'd1};
      4'd2:    r = '{pc: 3'd2, ca0: 5'd16, ca1: 5'd2};
      4'd3:    r = '{pc: 3'd2, ca0: 5'd6,  ca1: 5'd12};
      4'd4:    r = '{pc: 3'd3, ca0: 5'd14, ca1: 5'd4};
      4'd5:    r = '{pc: 3'd3, ca0: 5'd4,  ca1: 5'd14};
      4'd6:    r = '{pc: 3'd4, ca0: 5'd12, ca1: 5'd6};
      4'd7:    r = '{pc: 3'd4, ca0: 5'd2,  ca1: 5'd16};
      4'd8:    r = '{pc: 3'd5, ca0: 5'd10, ca1: 5'd8};
      default: r = '{pc: LastIdx, ca0: 5'd1, ca1: 5'd0};
    endcase
    return r;
  endfunction

  function automatic logic [1:0] chg_class(logic [2:0] pc);
    logic [1:0] cc;
    unique case (pc) inside
      3'd0, 3'd1:             cc = 2'd0;
      3'd2, 3'd3, 3'd4, 3'd5: cc = 2'd1;
      default:                cc = 2'd2;
    endcase
    return cc;
  endfunction

  // Product of the error span and the change span of a cell
  function automatic logic [9:0] den_of(logic [2:0] pe, logic [2:0] pc);
    logic [5:0] de;
    logic [4:0] dc;
    unique case (pe) inside
      3'd0:       de = 6'd23;
      3'd1:       de = 6'd26;
      3'd2, 3'd3: de = 6'd31;
      3'd4:       de = 6'd37;
      3'd5:       de = 6'd47;
      default:    de = 6'd1;
    endcase
    unique case (chg_class(pc))
      2'd0:    dc = 5'd9;
      2'd1:    dc = 5'd18;
      default: dc = 5'd1;
    endcase
    return 10'(de * dc);
  endfunction

  function automatic logic [RecipShift-1:0] recip_of(logic [2:0] pe, logic [2:0] pc);
    return RecipTab[pe][chg_class(pc)];
  endfunction

  function automatic logic [CentreW-1:0] centre_of(logic [CfgW-1:0] r, logic [2:0] c);
    return r[CentreW*c +: CentreW];
  endfunction

endpackage

[sv/fuzzy_gain_scheduler_top.sv]
// Top level of the seven-level fuzzy PD gain scheduler.
`timescale 1ns / 1ps

// Fuzzy gain scheduler: each input word carries a signed track offset and
// its change; the block returns one word with a proportional gain (Q1.8), a
// derivative gain (Q5.4) and a speed level (Q2.7), each the rounded
// membership-weighted mix of seven programmable centres. Sustained rate is
// one word per clock while the output does not stall. The front end
// (magnitude and breakpoint search) registers the word at the accept edge;
// it then passes the word queue register and the back-end stages, of which
// the last three form the reciprocal divider (multiply by table reciprocal,
// back-multiply, one-step correction) that does the rounding. The queue
// lets the front end keep taking words while the output is stalled, until
// it is full. Centre registers hold seven 9-bit fields each (centre i at
// bits 9i up) and are written through cfg_we_i / cfg_addr_i / cfg_data_i;
// only write them while no word is in flight. Writes to an unknown index
// are dropped.
module fuzzy_gain_scheduler_top #(
  parameter int unsigned QueueDepth = fgs_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fgs_pkg::in_word_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fgs_pkg::out_word_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [fgs_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [fgs_pkg::CfgW-1:0]     cfg_data_i
);

  // centre registers
  logic [fgs_pkg::CfgW-1:0] p_centres_q, d_centres_q, s_centres_q;

  // front -> queue -> back
  logic             push, take;
  fgs_pkg::class_t  cls, q_head;
  fgs_pkg::q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_centres_q <= fgs_pkg::PGainReset;
      d_centres_q <= fgs_pkg::DGainReset;
      s_centres_q <= fgs_pkg::SpeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fgs_pkg::CfgPGain: p_centres_q <= cfg_data_i;
        fgs_pkg::CfgDGain: d_centres_q <= cfg_data_i;
        fgs_pkg::CfgSpeed: s_centres_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classify: magnitudes, cells, membership weights
  fgs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cls_o      (cls)
  );

  fgs_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls),
    .pop_i       (take),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  // rules, weighted sums, rounding division, output register
  fgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_head_i    (q_head),
    .q_stat_i    (q_stat),
    .take_o      (take),
    .p_centres_i (p_centres_q),
    .d_centres_i (d_centres_q),
    .s_centres_i (s_centres_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // queue can never be full and empty at once
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // back end only pops a word that is there
  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  // an accepted word is pushed next cycle unless the queue is full
  a_accept_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (push || q_stat.full))
    else $error("accepted word not forwarded to queue");

endmodule

[sv/fgs_front.sv]
// Front end: magnitudes, breakpoint search and membership weights.
`timescale 1ns / 1ps

module fgs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fgs_pkg::in_word_t in_data_i,
  input  fgs_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output fgs_pkg::class_t   cls_o
);

  logic                      f_valid_q, f_valid_d;
  fgs_pkg::class_t           cls_q, cls_d;
  logic                      f_en;
  logic [16:0]               fe, fec;
  logic [fgs_pkg::Rank-2:0]  ge;
  logic [2:0]                pe, pe1;
  logic [3:0]                mc;
  fgs_pkg::chg_t             ch;

  function automatic logic [16:0] mag17(logic signed [15:0] x);
    logic [16:0] v;
    v = {1'b0, x};
    return x[15] ? 17'h10000 - v : v;
  endfunction

  always_comb begin
    fe  = mag17(in_data_i.track_offset);
    fec = mag17(in_data_i.offset_change);
    for (int j = 1; j < fgs_pkg::Rank; j++) begin
      ge[j-1] = fe >= 17'(fgs_pkg::EBp[j]);
    end
    pe  = 3'($countones(ge));
    pe1 = (pe == fgs_pkg::LastIdx) ? pe : 3'(pe + 3'd1);
    mc  = (fec >= 17'd9) ? 4'd9 : fec[3:0];
    ch  = fgs_pkg::chg_locate(mc);

    cls_d.pe  = pe;
    cls_d.pe1 = pe1;
    cls_d.pc  = ch.pc;
    cls_d.pc1 = (ch.pc == fgs_pkg::LastIdx) ? ch.pc : 3'(ch.pc + 3'd1);
    cls_d.ca0 = ch.ca0;
    cls_d.ca1 = ch.ca1;
    if (pe == fgs_pkg::LastIdx) begin
      cls_d.ea0 = 6'd1;
      cls_d.ea1 = 6'd0;
    end else begin
      cls_d.ea0 = 6'(fgs_pkg::EBp[pe1] - fe[7:0]);
      cls_d.ea1 = 6'(fe[7:0] - fgs_pkg::EBp[pe]);
    end
  end

  assign push_o     = f_valid_q && !q_stat_i.full;
  assign f_en       = !f_valid_q || !q_stat_i.full;
  assign in_stall_o = !f_en;
  assign f_valid_d  = f_en ? in_valid_i : f_valid_q;
  assign cls_o      = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en && in_valid_i) begin
      cls_q <= cls_d;
    end
  end

endmodule

[sv/fgs_queue.sv]
// Short FIFO of classified words between front and back end.
`timescale 1ns / 1ps

module fgs_queue #(
  parameter int unsigned QueueDepth = fgs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fgs_pkg::class_t  push_data_i,
  input  logic             pop_i,
  output fgs_pkg::class_t  head_o,
  output fgs_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  fgs_pkg::class_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == CntW'(QueueDepth);
  assign stat_o.empty = cnt_q == '0;

endmodule

[sv/fgs_back.sv]
// Back end: rule lookup, weighted sums and rounded reciprocal division.
`timescale 1ns / 1ps

module fgs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fgs_pkg::class_t             q_head_i,
  input  fgs_pkg::q_stat_t            q_stat_i,
  output logic                        take_o,
  input  logic [fgs_pkg::CfgW-1:0]    p_centres_i,
  input  logic [fgs_pkg::CfgW-1:0]    d_centres_i,
  input  logic [fgs_pkg::CfgW-1:0]    s_centres_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fgs_pkg::out_word_t          out_data_o
);

  localparam int unsigned NStages = 6;
  localparam int unsigned Cw      = fgs_pkg::CentreW;
  localparam int unsigned Rs      = fgs_pkg::RecipShift;
  localparam int unsigned NLanes  = 3;

  logic [NStages-1:0] v_q, v_d, adv;

  // stage 1: centres and cell weights
  logic [Cw-1:0] s1_cp_q [4];
  logic [Cw-1:0] s1_cd_q [4];
  logic [Cw-1:0] s1_cs_q [2];
  logic [9:0]    s1_w_q  [4];
  logic [5:0]    s1_ea_q [2];
  logic [2:0]    s1_pe_q, s1_pc_q;

  // stage 2: weighted centres
  logic [18:0]   s2_pp_q [4];
  logic [18:0]   s2_pd_q [4];
  logic [14:0]   s2_ps_q [2];
  logic [2:0]    s2_pe_q, s2_pc_q;

  // stages 3..6, one lane per output
  logic [Rs-1:0] s3_n_q [NLanes];
  logic [10:0]   s3_d_q [NLanes];
  logic [Rs-1:0] s3_r_q [NLanes];
  logic [Cw-1:0] s4_q0_q [NLanes];
  logic [Rs-1:0] s4_n_q  [NLanes];
  logic [10:0]   s4_d_q  [NLanes];
  logic [Rs-1:0] s5_qd_q [NLanes];
  logic [Cw-1:0] s5_q0_q [NLanes];
  logic [Rs-1:0] s5_n_q  [NLanes];
  logic [10:0]   s5_d_q  [NLanes];
  logic [Cw-1:0] s6_q_q  [NLanes];

  logic [2:0]    ei [4];
  logic [2:0]    ci [4];
  logic [5:0]    ew [4];
  logic [4:0]    cw [4];
  logic [18:0]   np, nd;
  logic [15:0]   ns;
  logic [9:0]    den_pd, den_s;
  logic [Rs-1:0] rem [NLanes];

  // Stall control: a stage advances when empty or when the next one does
  always_comb begin
    adv[NStages-1] = !v_q[NStages-1] || !out_stall_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d[0] = adv[0] ? !q_stat_i.empty : v_q[0];
    for (int k = 1; k < NStages; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  assign take_o = adv[0] && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Cell order: (pc,pe) (pc,pe1) (pc1,pe) (pc1,pe1)
  always_comb begin
    ei[0] = q_head_i.pe;  ci[0] = q_head_i.pc;  ew[0] = q_head_i.ea0; cw[0] = q_head_i.ca0;
    ei[1] = q_head_i.pe1; ci[1] = q_head_i.pc;  ew[1] = q_head_i.ea1; cw[1] = q_head_i.ca0;
    ei[2] = q_head_i.pe;  ci[2] = q_head_i.pc1; ew[2] = q_head_i.ea0; cw[2] = q_head_i.ca1;
    ei[3] = q_head_i.pe1; ci[3] = q_head_i.pc1; ew[3] = q_head_i.ea1; cw[3] = q_head_i.ca1;
  end

  always_comb begin
    np     = 19'(s2_pp_q[0] + s2_pp_q[1] + s2_pp_q[2] + s2_pp_q[3]);
    nd     = 19'(s2_pd_q[0] + s2_pd_q[1] + s2_pd_q[2] + s2_pd_q[3]);
    ns     = 16'(s2_ps_q[0] + s2_ps_q[1]);
    den_pd = fgs_pkg::den_of(s2_pe_q, s2_pc_q);
    den_s  = fgs_pkg::den_of(s2_pe_q, fgs_pkg::LastIdx);
    for (int l = 0; l < NLanes; l++) begin
      rem[l] = Rs'(s5_n_q[l] - s5_qd_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int j = 0; j < 4; j++) begin
        s1_cp_q[j] <= fgs_pkg::centre_of(p_centres_i, fgs_pkg::KpRules[ci[j]][ei[j]]);
        s1_cd_q[j] <= fgs_pkg::centre_of(d_centres_i, fgs_pkg::KdRules[ci[j]][ei[j]]);
        s1_w_q[j]  <= 10'(ew[j] * cw[j]);
      end
      s1_cs_q[0] <= fgs_pkg::centre_of(s_centres_i, fgs_pkg::SpeedRow[q_head_i.pe]);
      s1_cs_q[1] <= fgs_pkg::centre_of(s_centres_i, fgs_pkg::SpeedRow[q_head_i.pe1]);
      s1_ea_q[0] <= q_head_i.ea0;
      s1_ea_q[1] <= q_head_i.ea1;
      s1_pe_q    <= q_head_i.pe;
      s1_pc_q    <= q_head_i.pc;
    end
    if (adv[1]) begin
      for (int j = 0; j < 4; j++) begin
        s2_pp_q[j] <= 19'(s1_w_q[j] * s1_cp_q[j]);
        s2_pd_q[j] <= 19'(s1_w_q[j] * s1_cd_q[j]);
      end
      for (int j = 0; j < 2; j++) begin
        s2_ps_q[j] <= 15'(s1_ea_q[j] * s1_cs_q[j]);
      end
      s2_pe_q <= s1_pe_q;
      s2_pc_q <= s1_pc_q;
    end
    // Rounded quotient: (2*num + den) / (2*den)
    if (adv[2]) begin
      s3_n_q[0] <= Rs'({np, 1'b0}) + Rs'(den_pd);
      s3_n_q[1] <= Rs'({nd, 1'b0}) + Rs'(den_pd);
      s3_n_q[2] <= Rs'({ns, 1'b0}) + Rs'(den_s);
      s3_d_q[0] <= {den_pd, 1'b0};
      s3_d_q[1] <= {den_pd, 1'b0};
      s3_d_q[2] <= {den_s, 1'b0};
      s3_r_q[0] <= fgs_pkg::recip_of(s2_pe_q, s2_pc_q);
      s3_r_q[1] <= fgs_pkg::recip_of(s2_pe_q, s2_pc_q);
      s3_r_q[2] <= fgs_pkg::recip_of(s2_pe_q, fgs_pkg::LastIdx);
    end
    // Reciprocal estimate is exact or one low
    if (adv[3]) begin
      for (int l = 0; l < NLanes; l++) begin
        s4_q0_q[l] <= Cw'((2*Rs)'(s3_n_q[l] * s3_r_q[l]) >> Rs);
        s4_n_q[l]  <= s3_n_q[l];
        s4_d_q[l]  <= s3_d_q[l];
      end
    end
    if (adv[4]) begin
      for (int l = 0; l < NLanes; l++) begin
        s5_qd_q[l] <= Rs'(s4_q0_q[l] * s4_d_q[l]);
        s5_q0_q[l] <= s4_q0_q[l];
        s5_n_q[l]  <= s4_n_q[l];
        s5_d_q[l]  <= s4_d_q[l];
      end
    end
    if (adv[5]) begin
      for (int l = 0; l < NLanes; l++) begin
        s6_q_q[l] <= (rem[l] >= Rs'(s5_d_q[l])) ? Cw'(s5_q0_q[l] + 1'b1) : s5_q0_q[l];
      end
    end
  end

  assign out_valid_o            = v_q[NStages-1];
  assign out_data_o.p_gain      = s6_q_q[0];
  assign out_data_o.d_gain      = s6_q_q[1];
  assign out_data_o.speed_level = s6_q_q[2];

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the fuzzy gain scheduler top level.
`timescale 1ns / 1ps

// Drives offset/change words through the scheduler and checks every returned
// gain word against a cycle-free software schedule computed at input accept.
// A driver fed from a word queue sends in random bursts. The receiver stalls
// on a pattern of its own, with a long periodic hold-off that backs up the
// pipeline. Centre registers are reprogrammed between phases, only while
// nothing is in flight.
module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;   // idle margin after the last word is back
  localparam int unsigned HoldPeriod  = 500;  // receiver cycles between hold-offs
  localparam int unsigned HoldLength  = 60;   // long enough to fill the queue
  localparam logic [fgs_pkg::CfgAddrW-1:0] CfgNoReg = 2'd3;  // unmapped index

  localparam logic [fgs_pkg::CfgW-1:0] PDefault = 63'd3321135574393637023;
  localparam logic [fgs_pkg::CfgW-1:0] DDefault = 63'd2887379123326472288;
  localparam logic [fgs_pkg::CfgW-1:0] SDefault = 63'd6425534729258182464;
  localparam logic [fgs_pkg::CfgW-1:0] AllOnes  = '1;

  typedef int unsigned brk_t [7];
  typedef int unsigned rule_t [7][7];

  // error breakpoints, and change breakpoints in tenths
  localparam brk_t ErrBreak   = '{0, 23, 49, 80, 111, 148, 195};
  localparam brk_t ChgBreak10 = '{0, 9, 18, 36, 54, 72, 90};

  // rule tables, indexed [change cell][error cell]
  localparam rule_t PropRule = '{
    '{2, 2, 1, 1, 1, 0, 0},
    '{3, 3, 2, 1, 1, 1, 0},
    '{4, 3, 3, 2, 2, 1, 1},
    '{4, 4, 3, 3, 2, 1, 1},
    '{4, 4, 4, 3, 2, 2, 1},
    '{5, 5, 5, 4, 4, 3, 2},
    '{6, 6, 5, 5, 4, 3, 3}
  };
  localparam rule_t DerivRule = '{
    '{3, 3, 4, 5, 5, 6, 6},
    '{3, 3, 4, 4, 5, 5, 5},
    '{2, 3, 3, 4, 5, 5, 5},
    '{1, 2, 2, 3, 3, 4, 5},
    '{1, 1, 2, 2, 3, 3, 3},
    '{0, 1, 1, 1, 2, 2, 3},
    '{0, 0, 1, 1, 1, 2, 2}
  };
  // speed only sees the change-zero row
  localparam brk_t SpeedRule = '{3, 4, 5, 5, 2, 1, 1};

  typedef enum logic [1:0] {
    RxFlow,   // never stall
    RxLight,  // stall about one cycle in four
    RxHeavy   // stall about three quarters of the time
  } rx_mode_e;

  // DUT connections; every input is known from time zero
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  fgs_pkg::in_word_t            in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  fgs_pkg::out_word_t           out_data_o;
  logic                         cfg_we_i    = 1'b0;
  logic [fgs_pkg::CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [fgs_pkg::CfgW-1:0]     cfg_data_i  = '0;

  // Scoreboard state
  fgs_pkg::in_word_t  offset_words_q [$];   // words waiting for the driver
  fgs_pkg::out_word_t gain_expect_q  [$];   // schedules of accepted words, oldest first
  logic [fgs_pkg::CfgW-1:0] p_centres = PDefault;
  logic [fgs_pkg::CfgW-1:0] d_centres = DDefault;
  logic [fgs_pkg::CfgW-1:0] s_centres = SDefault;
  int unsigned words_issued  = 0;    // written only by the stimulus process
  int unsigned words_checked = 0;    // written only by the monitor
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  logic        in_fire       = 1'b0; // word taken at the last rising edge

  fuzzy_gain_scheduler_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Schedule predictor
  // ---------------------------------------------------------------------------

  // -32768 maps to 32768, which lands beyond the last breakpoint anyway
  function automatic int unsigned magnitude(logic [15:0] v);
    int unsigned u;
    u = 32'(v);
    return v[15] ? 32'd65536 - u : u;
  endfunction

  // Lower cell, the two membership weights and their common span. Past the
  // last breakpoint the last cell takes all the weight.
  function automatic void place_on(input brk_t bp, input int unsigned m,
                                   output int unsigned idx, output int unsigned w0,
                                   output int unsigned w1, output int unsigned span);
    idx  = 6;
    w0   = 1;
    w1   = 0;
    span = 1;
    for (int k = 5; k >= 0; k--) begin
      if (m < bp[k+1]) begin
        idx  = k;
        w0   = bp[k+1] - m;
        w1   = m - bp[k];
        span = bp[k+1] - bp[k];
      end
    end
  endfunction

  function automatic int unsigned centre_field(logic [fgs_pkg::CfgW-1:0] r,
                                               int unsigned c);
    return 32'(r[fgs_pkg::CentreW*c +: fgs_pkg::CentreW]);
  endfunction

  // nearest code, halves go up
  function automatic int unsigned round_half_up(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic fgs_pkg::out_word_t schedule_gains(fgs_pkg::in_word_t w);
    int unsigned fe, fc, fc10;
    int unsigned pe, ea0, ea1, eden, pe1;
    int unsigned pc, ca0, ca1, cden, pc1;
    int unsigned den, np, nd, ns;
    fgs_pkg::out_word_t r;
    fe   = magnitude(w.track_offset);
    fc   = magnitude(w.offset_change);
    fc10 = (fc >= 100) ? 1000 : fc * 10;
    place_on(ErrBreak, fe, pe, ea0, ea1, eden);
    place_on(ChgBreak10, fc10, pc, ca0, ca1, cden);
    pe1 = (pe < 6) ? pe + 1 : pe;
    pc1 = (pc < 6) ? pc + 1 : pc;
    den = eden * cden;
    np = ea0 * ca0 * centre_field(p_centres, PropRule[pc][pe])
       + ea1 * ca0 * centre_field(p_centres, PropRule[pc][pe1])
       + ea0 * ca1 * centre_field(p_centres, PropRule[pc1][pe])
       + ea1 * ca1 * centre_field(p_centres, PropRule[pc1][pe1]);
    nd = ea0 * ca0 * centre_field(d_centres, DerivRule[pc][pe])
       + ea1 * ca0 * centre_field(d_centres, DerivRule[pc][pe1])
       + ea0 * ca1 * centre_field(d_centres, DerivRule[pc1][pe])
       + ea1 * ca1 * centre_field(d_centres, DerivRule[pc1][pe1]);
    ns = ea0 * centre_field(s_centres, SpeedRule[pe])
       + ea1 * centre_field(s_centres, SpeedRule[pe1]);
    r.p_gain      = fgs_pkg::CentreW'(round_half_up(np, den));
    r.d_gain      = fgs_pkg::CentreW'(round_half_up(nd, den));
    r.speed_level = fgs_pkg::CentreW'(round_half_up(ns, eden));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (offset_words_q.size() > 0) begin
        in_data_i  <= offset_words_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          // half of the bursts run back to back with no gap
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall modes of random length plus a periodic long hold-off,
  // counted here, while the driver keeps offering words.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode      = RxFlow;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_cycles    = 0;

  always @(negedge clk_i) begin
    rx_cycles = rx_cycles + 1;
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_cycles % HoldPeriod == HoldPeriod / 2) begin
      rx_hold_left = HoldLength;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 100);
      end
      rx_mode_left = rx_mode_left - 1;
      case (rx_mode)
        RxFlow:  out_stall_i <= 1'b0;
        RxLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input accept, compare on output accept
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fgs_pkg::out_word_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        gain_expect_q.push_back(schedule_gains(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (gain_expect_q.size() == 0) begin
          $error("unexpected gain word %h", out_data_o);
          fail_count = fail_count + 1;
        end else begin
          want = gain_expect_q.pop_front();
          words_checked <= words_checked + 1;
          if (out_data_o.p_gain !== want.p_gain) begin
            $error("p_gain mismatch: expected %0d, got %0d", want.p_gain, out_data_o.p_gain);
            fail_count = fail_count + 1;
          end
          if (out_data_o.d_gain !== want.d_gain) begin
            $error("d_gain mismatch: expected %0d, got %0d", want.d_gain, out_data_o.d_gain);
            fail_count = fail_count + 1;
          end
          if (out_data_o.speed_level !== want.speed_level) begin
            $error("speed_level mismatch: expected %0d, got %0d",
                   want.speed_level, out_data_o.speed_level);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [15:0] offset, input logic [15:0] change);
    fgs_pkg::in_word_t w;
    w.track_offset  = offset;
    w.offset_change = change;
    offset_words_q.push_back(w);
    words_issued = words_issued + 1;
  endtask

  // Mostly magnitudes around the breakpoints, a band around a chosen value,
  // and some full-range words so every bit toggles.
  function automatic logic [15:0] pick_field(int unsigned near_max, int unsigned band_lo,
                                             int unsigned band_hi);
    int unsigned sel;
    int unsigned m;
    logic [15:0] v;
    sel = $urandom_range(0, 9);
    if (sel >= 7) return 16'($urandom);
    m = (sel < 5) ? $urandom_range(0, near_max) : $urandom_range(band_lo, band_hi);
    v = 16'(m);
    if ($urandom_range(0, 1) == 1) v = ~v + 16'd1;
    return v;
  endfunction

  task automatic queue_random(input int unsigned n);
    @(posedge clk_i);
    repeat (n) push_word(pick_field(210, 185, 205), pick_field(12, 95, 105));
  endtask

  // Sender holds off until every word it issued has come back
  task automatic wait_drained;
    do @(negedge clk_i); while (words_checked != words_issued);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Programs all three centre sets; optionally a write to the unmapped index
  // first, which must leave everything untouched. Called at a falling edge.
  task automatic load_centres(input logic [fgs_pkg::CfgW-1:0] pv,
                              input logic [fgs_pkg::CfgW-1:0] dv,
                              input logic [fgs_pkg::CfgW-1:0] sv, input bit stray);
    if (stray) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= CfgNoReg;
      cfg_data_i <= fgs_pkg::CfgW'({$urandom, $urandom});
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= fgs_pkg::CfgPGain;
    cfg_data_i <= pv;
    p_centres  = pv;
    @(negedge clk_i);
    cfg_addr_i <= fgs_pkg::CfgDGain;
    cfg_data_i <= dv;
    d_centres  = dv;
    @(negedge clk_i);
    cfg_addr_i <= fgs_pkg::CfgSpeed;
    cfg_data_i <= sv;
    s_centres  = sv;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [fgs_pkg::CfgW-1:0] random_centres;
    return fgs_pkg::CfgW'({$urandom, $urandom});
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    wait_drained();

    // Reset centres: field extremes, breakpoints and their neighbours, the
    // most negative value, and both sides of the change clamp at 100.
    @(posedge clk_i);
    push_word(16'sd0,      16'sd0);
    push_word(16'sd32767,  16'sd0);
    push_word(-16'sd32768, 16'sd0);
    push_word(16'sd0,      16'sd32767);
    push_word(16'sd0,      -16'sd32768);
    push_word(16'sd32767,  -16'sd32768);
    push_word(-16'sd32768, -16'sd32768);
    push_word(-16'sd1,     16'sd1);
    push_word(16'sd1,      -16'sd1);
    push_word(16'sd22,     16'sd8);
    push_word(16'sd23,     16'sd9);
    push_word(-16'sd24,    -16'sd10);
    push_word(16'sd48,     16'sd4);
    push_word(16'sd49,     16'sd5);
    push_word(-16'sd80,    16'sd6);
    push_word(16'sd111,    -16'sd7);
    push_word(16'sd148,    16'sd99);
    push_word(-16'sd147,   16'sd100);
    push_word(16'sd194,    16'sd1);
    push_word(16'sd195,    16'sd2);
    push_word(-16'sd196,   16'sd3);
    push_word(16'sd60,     -16'sd9);
    push_word(16'sd100,    -16'sd8);
    queue_random(230);
    wait_drained();

    // All centres zero, then all ones
    load_centres('0, '0, '0, 1'b0);
    queue_random(200);
    wait_drained();
    load_centres(AllOnes, AllOnes, AllOnes, 1'b0);
    queue_random(200);
    wait_drained();

    // Random centres, with a full drain in the middle of the phase
    load_centres(random_centres(), random_centres(), random_centres(), 1'b0);
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    // Random centres behind a write to the unmapped index
    load_centres(random_centres(), random_centres(), random_centres(), 1'b1);
    queue_random(300);
    wait_drained();

    // Mixed extremes
    load_centres(AllOnes, '0, random_centres(), 1'b1);
    queue_random(300);
    wait_drained();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
